// ===== src/bccs_pkg.sv =====
// ----------------------------------------------------------------------------
// bccs_pkg
// Shared types and codes of the byte code processor step core: commands,
// opcodes, run status codes and the arithmetic unit interface.
// ----------------------------------------------------------------------------
`default_nettype none

package bccs_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned STAT_W = 3;

    // commands
    localparam logic [1:0] CMD_MEM_WR = 2'd0;
    localparam logic [1:0] CMD_RAM_WR = 2'd1;
    localparam logic [1:0] CMD_EXEC   = 2'd2;

    // opcodes
    localparam logic [7:0] OP_LOAD = 8'h01;
    localparam logic [7:0] OP_ADD  = 8'h02;
    localparam logic [7:0] OP_SUB  = 8'h03;
    localparam logic [7:0] OP_JMP  = 8'h04;
    localparam logic [7:0] OP_MUL  = 8'h05;
    localparam logic [7:0] OP_PUSH = 8'h06;
    localparam logic [7:0] OP_POP  = 8'h07;
    localparam logic [7:0] OP_JZ   = 8'h08;
    localparam logic [7:0] OP_JNZ  = 8'h09;
    localparam logic [7:0] OP_JC   = 8'h0A;
    localparam logic [7:0] OP_JNC  = 8'h0B;
    localparam logic [7:0] OP_CMP  = 8'h0C;
    localparam logic [7:0] OP_JE   = 8'h0D;
    localparam logic [7:0] OP_JL   = 8'h0E;
    localparam logic [7:0] OP_JG   = 8'h0F;
    localparam logic [7:0] OP_STOP = 8'hFF;

    // addressing modes
    localparam logic [1:0] MODE_IMM  = 2'd0;
    localparam logic [1:0] MODE_REG  = 2'd1;
    localparam logic [1:0] MODE_RAM  = 2'd2;
    localparam logic [1:0] MODE_RIND = 2'd3;

    // run status
    localparam logic [STAT_W-1:0] STAT_RUN  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_STOP = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BAD  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OVF  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_UNF  = 3'd4;

    // arithmetic unit operations
    localparam logic [2:0] ALU_LOAD = 3'd0;
    localparam logic [2:0] ALU_ADD  = 3'd1;
    localparam logic [2:0] ALU_SUB  = 3'd2;
    localparam logic [2:0] ALU_CMP  = 3'd3;
    localparam logic [2:0] ALU_MUL  = 3'd4;

    typedef struct packed {
        logic [2:0]        kind;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic                carry;
        logic                zero;
        logic                flags_we;
        logic [2*DATA_W-1:0] prod;
    } alu_res_t;

endpackage

`default_nettype wire

// ===== src/byte_code_cpu_step_core.sv =====
// ----------------------------------------------------------------------------
// byte_code_cpu_step_core
// Byte code processor stepped one command per transaction: code and stack
// memory writes, data RAM writes and single instruction execution.
// ----------------------------------------------------------------------------
// Each accepted transaction returns one snapshot of the machine. Writes,
// unknown commands and steps of a halted machine finish when accepted. An
// instruction fetches its opcode and operand bytes one per cycle through the
// code/stack memory's single port; it ends on its opcode if it halts there,
// on its first operand byte for mul, push and untaken jumps, on its second
// for load/add/sub, cmp and taken jumps, on a stack read for pop, and a data
// RAM read later in the data RAM modes. A finished snapshot sits in an output
// register, so the next command is accepted while it waits; a further
// instruction stalls at its end until the snapshot is taken. Data RAM entries
// read as zero until written (per-entry valid bits, no clearing pass).
`default_nettype none

module byte_code_cpu_step_core #(
    parameter int unsigned MEM_DEPTH = 65536,
    parameter int unsigned RAM_DEPTH = 256,
    parameter int unsigned NUM_REGS  = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [15:0] s_address,
    input  wire logic [7:0]  s_data,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [15:0]      m_prog_counter,
    output logic [15:0]      m_stack_ptr,
    output logic             m_carry_flag,
    output logic             m_zero_flag,
    output logic [7:0]       m_reg_a,
    output logic [7:0]       m_reg_b,
    output logic [7:0]       m_reg_c,
    output logic [7:0]       m_reg_d,
    output logic [7:0]       m_loop_reg,
    output logic [7:0]       m_arith_reg
);

    localparam int unsigned MEM_AW  = $clog2(MEM_DEPTH);
    localparam int unsigned RAM_AW  = $clog2(RAM_DEPTH);
    localparam int unsigned RIDX_W  = $clog2(NUM_REGS);

    localparam logic [RIDX_W-1:0] RIX_A    = RIDX_W'(0);
    localparam logic [RIDX_W-1:0] RIX_B    = RIDX_W'(1);
    localparam logic [RIDX_W-1:0] RIX_C    = RIDX_W'(2);
    localparam logic [RIDX_W-1:0] RIX_D    = RIDX_W'(3);
    localparam logic [RIDX_W-1:0] RIX_LOOP = RIDX_W'(4);
    localparam logic [RIDX_W-1:0] RIX_HI   = RIDX_W'(5);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP   = 3'd1;
    localparam logic [2:0] S_B1   = 3'd2;
    localparam logic [2:0] S_B2   = 3'd3;
    localparam logic [2:0] S_RAM  = 3'd4;
    localparam logic [2:0] S_POP  = 3'd5;

    function automatic logic [RIDX_W-1:0] rix(input logic [7:0] v);
        return v[RIDX_W-1:0];
    endfunction

    function automatic logic reg_ok(input logic [7:0] v);
        return (int'(v) < NUM_REGS);
    endfunction

    function automatic logic jump_taken(input logic [7:0] op, input logic c, input logic z);
        logic t;
        t = 1'b0;
        case (op)
            bccs_pkg::OP_JMP:                  t = 1'b1;
            bccs_pkg::OP_JZ, bccs_pkg::OP_JE:  t = z;
            bccs_pkg::OP_JNZ:                  t = !z;
            bccs_pkg::OP_JC, bccs_pkg::OP_JL:  t = c;
            bccs_pkg::OP_JNC:                  t = !c;
            bccs_pkg::OP_JG:                   t = !c && !z;
            default:                           t = 1'b0;
        endcase
        return t;
    endfunction

    // architectural state
    logic [2:0]  state_reg, state_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  b1_reg, b1_next;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] sp_reg, sp_next;
    logic        carry_reg, carry_next;
    logic        zero_reg, zero_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  regs_reg [NUM_REGS];
    logic [7:0]  regs_next [NUM_REGS];
    logic        pend_reg, pend_next;

    // output slot
    logic        m_valid_reg;
    logic [2:0]  out_status_reg;
    logic [15:0] out_pc_reg;
    logic [15:0] out_sp_reg;
    logic        out_carry_reg;
    logic        out_zero_reg;
    logic [7:0]  out_a_reg, out_b_reg, out_c_reg, out_d_reg, out_loop_reg, out_hi_reg;

    // memories
    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              ram_we, ram_re;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        ram_rdata;
    logic              ram_valid_reg [RAM_DEPTH];
    logic              ram_vld_q_reg;

    logic        out_free, copy, commit_ok, commit, accept;
    logic [15:0] pc1, pc2, pc3, sp_dec;
    logic [1:0]  mode;
    logic [7:0]  ram_val;

    bccs_pkg::alu_req_t alu_req;
    bccs_pkg::alu_res_t alu_res;

    assign out_free  = !m_valid_reg || m_ready;
    assign copy      = pend_reg && out_free;
    assign commit_ok = !pend_reg || out_free;
    assign s_ready   = (state_reg == S_IDLE) && commit_ok;
    assign accept    = s_valid && s_ready;

    assign pc1     = pc_reg + 16'd1;
    assign pc2     = pc_reg + 16'd2;
    assign pc3     = pc_reg + 16'd3;
    assign sp_dec  = sp_reg - 16'd1;
    assign mode    = b1_reg[7:6];
    assign ram_val = ram_vld_q_reg ? ram_rdata : 8'd0;

    bccs_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_main_mem (
        .aclk  (aclk),
        .wr_en (mem_we),
        .rd_en (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bccs_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_data_ram (
        .aclk  (aclk),
        .wr_en (ram_we),
        .rd_en (ram_re),
        .addr  (ram_addr),
        .wdata (s_data),
        .rdata (ram_rdata)
    );

    bccs_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // operand selection for the arithmetic unit
    always_comb begin
        alu_req.kind = bccs_pkg::ALU_LOAD;
        alu_req.a    = 8'd0;
        alu_req.b    = 8'd0;
        case (op_reg)
            bccs_pkg::OP_ADD: alu_req.kind = bccs_pkg::ALU_ADD;
            bccs_pkg::OP_SUB: alu_req.kind = bccs_pkg::ALU_SUB;
            bccs_pkg::OP_CMP: alu_req.kind = bccs_pkg::ALU_CMP;
            bccs_pkg::OP_MUL: alu_req.kind = bccs_pkg::ALU_MUL;
            default:          alu_req.kind = bccs_pkg::ALU_LOAD;
        endcase
        case (state_reg)
            S_B1: begin
                alu_req.a = regs_reg[RIX_A];
                alu_req.b = regs_reg[rix(mem_rdata)];
            end
            S_B2: begin
                if (op_reg == bccs_pkg::OP_CMP) begin
                    alu_req.a = regs_reg[rix(b1_reg)];
                    alu_req.b = regs_reg[rix(mem_rdata)];
                end else begin
                    alu_req.a = regs_reg[rix({2'b00, b1_reg[5:0]})];
                    alu_req.b = (mode == bccs_pkg::MODE_REG) ?
                                regs_reg[rix(mem_rdata)] : mem_rdata;
                end
            end
            S_RAM: begin
                alu_req.a = regs_reg[rix({2'b00, b1_reg[5:0]})];
                alu_req.b = ram_val;
            end
            default: begin
                alu_req.a = 8'd0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        b1_next     = b1_reg;
        pc_next     = pc_reg;
        sp_next     = sp_reg;
        carry_next  = carry_reg;
        zero_next   = zero_reg;
        status_next = status_reg;
        regs_next   = regs_reg;
        commit      = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = pc_reg[MEM_AW-1:0];
        mem_wdata   = s_data;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = s_address[RAM_AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_command)
                        bccs_pkg::CMD_MEM_WR: begin
                            mem_we   = 1'b1;
                            mem_addr = s_address[MEM_AW-1:0];
                            commit   = 1'b1;
                        end
                        bccs_pkg::CMD_RAM_WR: begin
                            ram_we = 1'b1;
                            commit = 1'b1;
                        end
                        bccs_pkg::CMD_EXEC: begin
                            if (status_reg != bccs_pkg::STAT_RUN) begin
                                commit = 1'b1;
                            end else begin
                                mem_re     = 1'b1;
                                state_next = S_OP;
                            end
                        end
                        default: begin
                            commit = 1'b1;
                        end
                    endcase
                end
            end

            S_OP: begin
                op_next = mem_rdata;
                case (mem_rdata)
                    bccs_pkg::OP_LOAD, bccs_pkg::OP_ADD, bccs_pkg::OP_SUB,
                    bccs_pkg::OP_CMP, bccs_pkg::OP_MUL, bccs_pkg::OP_PUSH,
                    bccs_pkg::OP_JMP, bccs_pkg::OP_JZ, bccs_pkg::OP_JNZ,
                    bccs_pkg::OP_JC, bccs_pkg::OP_JNC, bccs_pkg::OP_JE,
                    bccs_pkg::OP_JL, bccs_pkg::OP_JG: begin
                        mem_re     = 1'b1;
                        mem_addr   = pc1[MEM_AW-1:0];
                        state_next = S_B1;
                    end
                    bccs_pkg::OP_POP: begin
                        if (sp_reg == 16'hFFFF) begin
                            if (commit_ok) begin
                                status_next = bccs_pkg::STAT_UNF;
                                pc_next     = pc1;
                                commit      = 1'b1;
                                state_next  = S_IDLE;
                            end
                        end else begin
                            mem_re     = 1'b1;
                            mem_addr   = pc1[MEM_AW-1:0];
                            state_next = S_B1;
                        end
                    end
                    bccs_pkg::OP_STOP: begin
                        if (commit_ok) begin
                            status_next = bccs_pkg::STAT_STOP;
                            pc_next     = pc1;
                            commit      = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    default: begin
                        if (commit_ok) begin
                            status_next = bccs_pkg::STAT_BAD;
                            pc_next     = pc1;
                            commit      = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                endcase
            end

            S_B1: begin
                b1_next = mem_rdata;
                case (op_reg)
                    bccs_pkg::OP_LOAD, bccs_pkg::OP_ADD, bccs_pkg::OP_SUB,
                    bccs_pkg::OP_CMP: begin
                        mem_re     = 1'b1;
                        mem_addr   = pc2[MEM_AW-1:0];
                        state_next = S_B2;
                    end
                    bccs_pkg::OP_MUL: begin
                        if (commit_ok) begin
                            if (!reg_ok(mem_rdata)) begin
                                status_next = bccs_pkg::STAT_BAD;
                                pc_next     = pc1;
                            end else begin
                                regs_next[RIX_HI] = alu_res.prod[15:8];
                                regs_next[RIX_A]  = alu_res.prod[7:0];
                                pc_next           = pc2;
                            end
                            commit     = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    bccs_pkg::OP_PUSH: begin
                        if (commit_ok) begin
                            if (!reg_ok(mem_rdata)) begin
                                status_next = bccs_pkg::STAT_BAD;
                                pc_next     = pc1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_addr  = sp_dec[MEM_AW-1:0];
                                mem_wdata = regs_reg[rix(mem_rdata)];
                                sp_next   = sp_dec;
                                pc_next   = pc2;
                                if (sp_dec <= pc2) begin
                                    status_next = bccs_pkg::STAT_OVF;
                                end
                            end
                            commit     = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    bccs_pkg::OP_POP: begin
                        if (!reg_ok(mem_rdata)) begin
                            if (commit_ok) begin
                                status_next = bccs_pkg::STAT_BAD;
                                pc_next     = pc1;
                                commit      = 1'b1;
                                state_next  = S_IDLE;
                            end
                        end else begin
                            mem_re     = 1'b1;
                            mem_addr   = sp_reg[MEM_AW-1:0];
                            state_next = S_POP;
                        end
                    end
                    default: begin
                        // jumps
                        if (jump_taken(op_reg, carry_reg, zero_reg)) begin
                            mem_re     = 1'b1;
                            mem_addr   = pc2[MEM_AW-1:0];
                            state_next = S_B2;
                        end else if (commit_ok) begin
                            pc_next    = pc3;
                            commit     = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_B2: begin
                case (op_reg)
                    bccs_pkg::OP_CMP: begin
                        if (commit_ok) begin
                            if (!reg_ok(b1_reg) || !reg_ok(mem_rdata)) begin
                                status_next = bccs_pkg::STAT_BAD;
                                pc_next     = pc1;
                            end else begin
                                carry_next = alu_res.carry;
                                zero_next  = alu_res.zero;
                                pc_next    = pc3;
                            end
                            commit     = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    bccs_pkg::OP_LOAD, bccs_pkg::OP_ADD, bccs_pkg::OP_SUB: begin
                        if (!reg_ok({2'b00, b1_reg[5:0]}) ||
                            ((mode == bccs_pkg::MODE_REG || mode == bccs_pkg::MODE_RIND) &&
                             !reg_ok(mem_rdata))) begin
                            if (commit_ok) begin
                                status_next = bccs_pkg::STAT_BAD;
                                pc_next     = pc1;
                                commit      = 1'b1;
                                state_next  = S_IDLE;
                            end
                        end else if (mode == bccs_pkg::MODE_RAM) begin
                            ram_re     = 1'b1;
                            ram_addr   = mem_rdata[RAM_AW-1:0];
                            state_next = S_RAM;
                        end else if (mode == bccs_pkg::MODE_RIND) begin
                            ram_re     = 1'b1;
                            ram_addr   = regs_reg[rix(mem_rdata)][RAM_AW-1:0];
                            state_next = S_RAM;
                        end else if (commit_ok) begin
                            regs_next[rix({2'b00, b1_reg[5:0]})] = alu_res.value;
                            if (alu_res.flags_we) begin
                                carry_next = alu_res.carry;
                                zero_next  = alu_res.zero;
                            end
                            pc_next    = pc3;
                            commit     = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default: begin
                        // taken jump, big-endian target
                        if (commit_ok) begin
                            pc_next    = {b1_reg, mem_rdata};
                            commit     = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_RAM: begin
                if (commit_ok) begin
                    regs_next[rix({2'b00, b1_reg[5:0]})] = alu_res.value;
                    if (alu_res.flags_we) begin
                        carry_next = alu_res.carry;
                        zero_next  = alu_res.zero;
                    end
                    pc_next    = pc3;
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_POP: begin
                if (commit_ok) begin
                    regs_next[rix(b1_reg)] = mem_rdata;
                    pc_next    = pc2;
                    sp_next    = sp_reg + 16'd1;
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign pend_next = commit ? 1'b1 : (copy ? 1'b0 : pend_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= 16'd0;
            sp_reg      <= 16'hFFFF;
            carry_reg   <= 1'b0;
            zero_reg    <= 1'b0;
            status_reg  <= bccs_pkg::STAT_RUN;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= 8'd0;
            end
            for (int j = 0; j < RAM_DEPTH; j++) begin
                ram_valid_reg[j] <= 1'b0;
            end
        end else begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            sp_reg     <= sp_next;
            carry_reg  <= carry_next;
            zero_reg   <= zero_next;
            status_reg <= status_next;
            pend_reg   <= pend_next;
            regs_reg   <= regs_next;
            if (ram_we) begin
                ram_valid_reg[ram_addr] <= 1'b1;
            end
            if (copy) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        b1_reg <= b1_next;
        if (ram_re) begin
            ram_vld_q_reg <= ram_valid_reg[ram_addr];
        end
        if (copy) begin
            out_status_reg <= status_reg;
            out_pc_reg     <= pc_reg;
            out_sp_reg     <= sp_reg;
            out_carry_reg  <= carry_reg;
            out_zero_reg   <= zero_reg;
            out_a_reg      <= regs_reg[RIX_A];
            out_b_reg      <= regs_reg[RIX_B];
            out_c_reg      <= regs_reg[RIX_C];
            out_d_reg      <= regs_reg[RIX_D];
            out_loop_reg   <= regs_reg[RIX_LOOP];
            out_hi_reg     <= regs_reg[RIX_HI];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_status_reg;
    assign m_prog_counter = out_pc_reg;
    assign m_stack_ptr    = out_sp_reg;
    assign m_carry_flag   = out_carry_reg;
    assign m_zero_flag    = out_zero_reg;
    assign m_reg_a        = out_a_reg;
    assign m_reg_b        = out_b_reg;
    assign m_reg_c        = out_c_reg;
    assign m_reg_d        = out_d_reg;
    assign m_loop_reg     = out_loop_reg;
    assign m_arith_reg    = out_hi_reg;

    // a halted machine stays halted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg != bccs_pkg::STAT_RUN) |=> (status_reg == $past(status_reg)))
        else $error("halt status changed");

    // no new transaction while an instruction is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input ready during execution");

    // a finished item never overwrites a snapshot not yet moved to the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (!pend_reg || out_free))
        else $error("snapshot overwritten");

    // stack pointer moves by one at most
    assert property (@(posedge aclk) disable iff (!aresetn)
        (sp_reg != $past(sp_reg)) |->
        (sp_reg == $past(sp_reg) + 16'd1 || sp_reg == $past(sp_reg) - 16'd1))
        else $error("stack pointer jump");

endmodule

`default_nettype wire

// ===== src/bccs_ram.sv =====
// ----------------------------------------------------------------------------
// bccs_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bccs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end else if (rd_en) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/bccs_alu.sv =====
// ----------------------------------------------------------------------------
// bccs_alu
// Byte arithmetic unit: load pass-through, add, sub, compare and 8x8 multiply
// with carry and zero flag results.
// ----------------------------------------------------------------------------
`default_nettype none

module bccs_alu (
    input  wire bccs_pkg::alu_req_t req,
    output bccs_pkg::alu_res_t      res
);

    logic [bccs_pkg::DATA_W:0] sum;
    logic [bccs_pkg::DATA_W:0] diff;

    assign sum  = {1'b0, req.a} + {1'b0, req.b};
    assign diff = {1'b0, req.a} - {1'b0, req.b};

    always_comb begin
        res.value    = req.b;
        res.carry    = 1'b0;
        res.zero     = 1'b0;
        res.flags_we = 1'b0;
        res.prod     = {{bccs_pkg::DATA_W{1'b0}}, req.a} * {{bccs_pkg::DATA_W{1'b0}}, req.b};
        case (req.kind)
            bccs_pkg::ALU_LOAD: begin
                res.value = req.b;
            end
            bccs_pkg::ALU_ADD: begin
                res.value    = sum[bccs_pkg::DATA_W-1:0];
                res.carry    = sum[bccs_pkg::DATA_W];
                res.zero     = (sum[bccs_pkg::DATA_W-1:0] == '0);
                res.flags_we = 1'b1;
            end
            bccs_pkg::ALU_SUB: begin
                res.value    = diff[bccs_pkg::DATA_W-1:0];
                res.carry    = diff[bccs_pkg::DATA_W];
                res.zero     = (diff[bccs_pkg::DATA_W-1:0] == '0);
                res.flags_we = 1'b1;
            end
            bccs_pkg::ALU_CMP: begin
                res.carry    = diff[bccs_pkg::DATA_W];
                res.zero     = (req.a == req.b);
                res.flags_we = 1'b1;
            end
            bccs_pkg::ALU_MUL: begin
                res.value = res.prod[bccs_pkg::DATA_W-1:0];
            end
            default: begin
                res.value = req.b;
            end
        endcase
    end

endmodule

`default_nettype wire
